// ===== hdl/huffman_tree_walk_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder_defines
// assertion macros used by the decoder datapath
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HTWD_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HTWD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/htwd_pkg.sv =====
// ----------------------------------------------------------------------------
// htwd_pkg
// types and constants shared by the tree walk decoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htwd_pkg;

   // request kinds carried on tuser
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // register index of total_symbols (paddr bit 2)
   localparam logic REG_TOTAL_SYMBOLS = 1'b0;

   // index of the last bit of a data byte
   localparam logic [2:0] LAST_BIT = 3'd7;

   // one tree node as held in the node memory
   typedef struct packed {
      logic       leaf;
      logic [7:0] symbol;
      logic [8:0] left;
      logic [8:0] right;
   } node_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // write one node
      logic start;  // latch a data byte, begin walk
      logic step;   // move to the child picked by the current bit
      logic emit;   // current node is a leaf: emit it
      logic flush;  // push the held symbol as last of the run
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic leaf;        // current node is a leaf
      logic hit_total;   // one more symbol reaches the total
      logic pend_valid;  // a symbol is held back
      logic out_free;    // output register can take a symbol
      logic skip;        // decode request is to be ignored
      logic last_bit;    // walking the last bit of the byte
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/htwd_dp.sv =====
// ----------------------------------------------------------------------------
// htwd_dp
// datapath: node memory, walk registers, symbol counter and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "huffman_tree_walk_decoder_defines.svh"

module htwd_dp #(
   parameter int NODE_DEPTH = 512
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire htwd_pkg::cmd_type    cmd,
   output htwd_pkg::status_type      st,
   input  wire logic [8:0]           node_addr,
   input  wire logic                 node_is_leaf,
   input  wire logic [7:0]           node_symbol,
   input  wire logic [8:0]           left_index,
   input  wire logic [8:0]           right_index,
   input  wire logic [7:0]           data_byte,
   input  wire logic [31:0]          total_symbols,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser
);

   localparam int          ADDR_W  = $clog2(NODE_DEPTH);
   localparam int          EXT_W   = (ADDR_W > 9) ? ADDR_W : 9;
   localparam logic [31:0] DEPTH_W = 32'(NODE_DEPTH);

   htwd_pkg::node_type mem [NODE_DEPTH];

   htwd_pkg::node_type node_q_ff;
   logic               node_ok_ff;
   htwd_pkg::node_type root_ff;
   logic [8:0]         cur_ff;
   logic [7:0]         byte_ff;
   logic [2:0]         bit_ff;
   logic [31:0]        count_ff;
   logic               finished_ff;
   logic               pend_valid_ff;
   logic [7:0]         pend_sym_ff;
   logic               pend_final_ff;
   logic               out_valid_ff;
   logic [7:0]         out_sym_ff;
   logic               out_last_ff;
   logic               out_final_ff;

   htwd_pkg::node_type node_eff;
   htwd_pkg::node_type base;
   htwd_pkg::node_type wr_node;
   logic               walk_bit;
   logic [8:0]         child;
   logic [8:0]         rd_idx;
   logic               rd_ok;
   logic [EXT_W-1:0]   rd_ext;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_ok;
   logic [EXT_W-1:0]   wr_ext;
   logic [ADDR_W-1:0]  wr_addr;
   logic [31:0]        count_inc;
   logic               out_free;
   logic               push_run;
   logic               push_close;
   logic               out_valid_in;

   // node seen by the walk; out-of-table children read as an empty node
   assign node_eff = node_ok_ff ? node_q_ff : '0;

   // child selection: after an emitted leaf the walk restarts from the root
   assign walk_bit = byte_ff[bit_ff];
   assign base     = cmd.emit ? root_ff : node_eff;
   assign child    = walk_bit ? base.right : base.left;

   // read address: next child when stepping, else the current node
   assign rd_idx  = cmd.step ? child : cur_ff;
   assign rd_ok   = 32'(rd_idx) < DEPTH_W;
   assign rd_ext  = EXT_W'(rd_idx);
   assign rd_addr = rd_ext[ADDR_W-1:0];

   // node load address
   assign wr_ok   = 32'(node_addr) < DEPTH_W;
   assign wr_ext  = EXT_W'(node_addr);
   assign wr_addr = wr_ext[ADDR_W-1:0];
   assign wr_node = '{leaf: node_is_leaf, symbol: node_symbol,
                      left: left_index, right: right_index};

   assign count_inc  = count_ff + 32'd1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign push_run   = cmd.emit && pend_valid_ff;
   assign push_close = cmd.flush;

   // status to the controller
   always_comb begin
      st.leaf       = node_eff.leaf;
      st.hit_total  = count_inc >= total_symbols;
      st.pend_valid = pend_valid_ff;
      st.out_free   = out_free;
      st.skip       = finished_ff || (total_symbols == 32'd0) || (count_ff >= total_symbols);
      st.last_bit   = bit_ff == htwd_pkg::LAST_BIT;
   end

   // node memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         mem[wr_addr] <= wr_node;
      end
   end

   always_ff @(posedge clock) begin
      node_q_ff  <= mem[rd_addr];
      node_ok_ff <= rd_ok;
   end

   // root copy, so a restart needs no second memory read
   always_ff @(posedge clock) begin
      if (cmd.load && (node_addr == 9'd0)) begin
         root_ff <= wr_node;
      end
   end

   // latched byte
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         byte_ff <= data_byte;
      end
   end

   // walk position and bit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= 9'd0;
         bit_ff <= 3'd0;
      end else begin
         if (cmd.step) begin
            cur_ff <= child;
         end
         if (cmd.start) begin
            bit_ff <= 3'd0;
         end else if (cmd.step) begin
            bit_ff <= bit_ff + 3'd1;
         end
      end
   end

   // symbol counter and stop flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= 32'd0;
         finished_ff <= 1'b0;
      end else if (cmd.emit) begin
         count_ff <= count_inc;
         if (st.hit_total) begin
            finished_ff <= 1'b1;
         end
      end
   end

   // held symbol: its last flag is known only once the next one or the byte end shows up
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pend_sym_ff   <= node_eff.symbol;
         pend_final_ff <= st.hit_total;
      end
   end

   // output register
   assign out_valid_in = (push_run || push_close) ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_run || push_close) begin
         out_sym_ff   <= pend_sym_ff;
         out_last_ff  <= push_close;
         out_final_ff <= pend_final_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_final_ff;

   // checks
   `HTWD_ASSERT_HOLDS(a_push_into_free, push_run || push_close, out_free, "symbol pushed over an untaken result")
   `HTWD_ASSERT_HOLDS(a_start_clean, cmd.start, !pend_valid_ff, "byte started with a symbol still held")
   `HTWD_ASSERT_NEXT(a_final_held, cmd.emit && st.hit_total, pend_valid_ff && pend_final_ff, "final symbol not held for closing")
   `HTWD_ASSERT_NEXT(a_finish_cause, !finished_ff && !(cmd.emit && st.hit_total), !finished_ff, "stop flag set without reaching the total")

endmodule

`default_nettype wire

// ===== hdl/htwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// htwd_ctrl
// controller: request handshake and sequencing of the bit walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htwd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic                  op,
   input  wire htwd_pkg::status_type  st,
   output htwd_pkg::cmd_type          cmd
);

   htwd_pkg::state_type state_ff;
   htwd_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= htwd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         htwd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (op == htwd_pkg::OP_LOAD) begin
                  cmd.load = 1'b1;
               end else if (!st.skip) begin
                  cmd.start = 1'b1;
                  state_in  = htwd_pkg::ST_WALK;
               end
            end
         end
         htwd_pkg::ST_WALK: begin
            if (st.leaf) begin
               // a held symbol must leave before a new one takes its place
               if (!st.pend_valid || st.out_free) begin
                  cmd.emit = 1'b1;
                  if (st.hit_total) begin
                     state_in = htwd_pkg::ST_FLUSH;
                  end else begin
                     cmd.step = 1'b1;
                     if (st.last_bit) begin
                        state_in = htwd_pkg::ST_FLUSH;
                     end
                  end
               end
            end else begin
               cmd.step = 1'b1;
               if (st.last_bit) begin
                  state_in = htwd_pkg::ST_FLUSH;
               end
            end
         end
         htwd_pkg::ST_FLUSH: begin
            if (!st.pend_valid) begin
               state_in = htwd_pkg::ST_IDLE;
            end else if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = htwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = htwd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/huffman_tree_walk_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_walk_decoder
// tree walk decoder with a loadable node table and a symbol total register
// ----------------------------------------------------------------------------
// A load request (tuser 0) writes one node. A decode request (tuser 1) is
// accepted, walks its bits least significant first and then closes its run;
// no new request is taken until it is done, and it also waits while a
// finished symbol waits for rsp_tready. Each bit step is bound by one
// dependent read of the node memory, whose registered output feeds the next
// read address. Symbols come out one per response; tlast marks the last
// symbol of a byte and tuser marks the symbol that reaches total_symbols,
// after which decode requests are dropped until reset. A dropped decode
// request gives no response.
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_walk_decoder #(
   parameter int NODE_DEPTH = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [8:0] node_addr, [9] node_is_leaf, [17:10] node_symbol,
   // [26:18] left_index, [35:27] right_index, [43:36] data_byte
   input  wire logic [47:0] req_tdata,
   // [0] op
   input  wire logic        req_tuser,
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] symbol
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   // [0] final_symbol
   output logic             rsp_tuser,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [31:0]          total_ff;
   logic                 csr_write;
   htwd_pkg::cmd_type    cmd;
   htwd_pkg::status_type st;

   // total_symbols register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 32'd0;
      end else if (csr_write && (csr_paddr[2] == htwd_pkg::REG_TOTAL_SYMBOLS)) begin
         total_ff <= csr_pwdata;
      end
   end

   assign csr_prdata = (csr_paddr[2] == htwd_pkg::REG_TOTAL_SYMBOLS) ? total_ff : 32'd0;

   htwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser),
      .st         (st),
      .cmd        (cmd)
   );

   htwd_dp #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .node_addr     (req_tdata[8:0]),
      .node_is_leaf  (req_tdata[9]),
      .node_symbol   (req_tdata[17:10]),
      .left_index    (req_tdata[26:18]),
      .right_index   (req_tdata[35:27]),
      .data_byte     (req_tdata[43:36]),
      .total_symbols (total_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

`default_nettype wire
